FILE: design/adsr_envelope_shaper_macros.svh
// ----------------------------------------------------------------------------
// adsr_envelope_shaper_macros.svh
// Assertion helpers used by the envelope shaper checker.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_SHAPER_MACROS_SVH
`define ADSR_ENVELOPE_SHAPER_MACROS_SVH

// Concurrent check, masked while reset is asserted
`define ADSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset
`define ADSR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes and types of the ADSR envelope shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

    // Fixed-point format of phase, lengths and levels
    localparam int FRAC_BITS  = 16;
    localparam int BND_W      = FRAC_BITS + 2;          // running boundary sums
    localparam int PROD_W     = 2 * FRAC_BITS;          // product / numerator
    localparam int SEG_W      = 3;

    // Divider: two quotient bits per stage
    localparam int DIV_STAGES = (FRAC_BITS + 1) / 2;
    localparam int QUOT_W     = 2 * DIV_STAGES;
    localparam int DIVX_W     = FRAC_BITS + QUOT_W;

    // Stream widths, whole bytes
    localparam int IN_W       = ((FRAC_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((FRAC_BITS + SEG_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ATK_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATK_LVL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUS_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUS_LVL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REL_LEN = 3'd5;

    // Register reset values, scaled to the format
    localparam logic [FRAC_BITS-1:0] RST_ATK_LEN = FRAC_BITS'(1) << (FRAC_BITS - 3);
    localparam logic [FRAC_BITS-1:0] RST_ATK_LVL = '1;
    localparam logic [FRAC_BITS-1:0] RST_DEC_LEN = FRAC_BITS'(1) << (FRAC_BITS - 3);
    localparam logic [FRAC_BITS-1:0] RST_SUS_LEN = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] RST_SUS_LVL = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] RST_REL_LEN = FRAC_BITS'(1) << (FRAC_BITS - 2);

    // Segment codes
    localparam logic [SEG_W-1:0] SEG_ATTACK  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_DECAY   = 3'd1;
    localparam logic [SEG_W-1:0] SEG_SUSTAIN = 3'd2;
    localparam logic [SEG_W-1:0] SEG_RELEASE = 3'd3;
    localparam logic [SEG_W-1:0] SEG_DONE    = 3'd4;

    // Sideband that rides along with the division
    typedef struct packed {
        logic [SEG_W-1:0]     seg;
        logic                 bypass;   // level is fixed, quotient ignored
        logic [FRAC_BITS-1:0] blev;     // fixed level
    } t_side;

endpackage

`default_nettype wire

FILE: design/adsr_div.sv
// ----------------------------------------------------------------------------
// adsr_div
// Pipelined restoring divider, two quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [adsr_pkg::PROD_W-1:0]       i_num,
    input  wire logic [adsr_pkg::FRAC_BITS-1:0]    i_den,
    input  wire adsr_pkg::t_side                   i_side,
    output logic                                   o_valid,
    output logic [adsr_pkg::FRAC_BITS-1:0]         o_quot,
    output adsr_pkg::t_side                        o_side
);

    localparam int F  = adsr_pkg::FRAC_BITS;
    localparam int S  = adsr_pkg::DIV_STAGES;
    localparam int QW = adsr_pkg::QUOT_W;
    localparam int XW = adsr_pkg::DIVX_W;

    // One restoring step: shift in a bit, subtract if it fits
    function automatic logic [F:0] div_step(input logic [F-1:0] rem, input logic b,
                                            input logic [F-1:0] den);
        logic [F:0] t;
        logic [F:0] d;
        t = {rem, b};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            return {1'b1, d[F-1:0]};
        end else begin
            return {1'b0, t[F-1:0]};
        end
    endfunction

    logic [XW-1:0]        w_numx;
    logic [F-1:0]         a_rem  [S];
    logic [QW-1:0]        a_lo   [S];
    logic [QW-1:0]        a_q    [S];
    logic [F-1:0]         a_den  [S];
    adsr_pkg::t_side      a_side [S];
    logic [S-1:0]         a_v;
    logic [F-1:0]         n_rem  [S];
    logic [QW-1:0]        n_lo   [S];
    logic [QW-1:0]        n_q    [S];
    logic [F-1:0]         r_rem  [S];
    logic [QW-1:0]        r_lo   [S];
    logic [QW-1:0]        r_q    [S];
    logic [F-1:0]         r_den  [S];
    adsr_pkg::t_side      r_side [S];
    logic [S-1:0]         r_v;

    // Quotient always fits F bits, so the top F bits start below the divisor
    assign w_numx = XW'(i_num);

    // Stage inputs
    always_comb begin
        a_rem[0]  = w_numx[XW-1:QW];
        a_lo[0]   = w_numx[QW-1:0];
        a_q[0]    = '0;
        a_den[0]  = i_den;
        a_side[0] = i_side;
        a_v[0]    = i_valid;
        for (int k = 1; k < S; k++) begin
            a_rem[k]  = r_rem[k-1];
            a_lo[k]   = r_lo[k-1];
            a_q[k]    = r_q[k-1];
            a_den[k]  = r_den[k-1];
            a_side[k] = r_side[k-1];
            a_v[k]    = r_v[k-1];
        end
    end

    // Two dependent steps per stage
    always_comb begin
        logic [F:0] s1;
        logic [F:0] s2;
        for (int k = 0; k < S; k++) begin
            s1       = div_step(a_rem[k], a_lo[k][QW-1], a_den[k]);
            s2       = div_step(s1[F-1:0], a_lo[k][QW-2], a_den[k]);
            n_rem[k] = s2[F-1:0];
            n_lo[k]  = {a_lo[k][QW-3:0], 2'b00};
            n_q[k]   = {a_q[k][QW-3:0], s1[F], s2[F]};
        end
    end

    // Stage registers; valid bits cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= a_v;
        end
        if (i_en) begin
            for (int k = 0; k < S; k++) begin
                r_rem[k]  <= n_rem[k];
                r_lo[k]   <= n_lo[k];
                r_q[k]    <= n_q[k];
                r_den[k]  <= a_den[k];
                r_side[k] <= a_side[k];
            end
        end
    end

    assign o_valid = r_v[S-1];
    assign o_quot  = r_q[S-1][F-1:0];
    assign o_side  = r_side[S-1];

endmodule

`default_nettype wire

FILE: design/adsr_envelope_shaper.sv
// Stages at Q0.16: capture, segment select, two products, sum, divider, output register.
// Throughput: one phase per clock; the whole pipeline advances together and
// holds while the output register waits for its transfer.
// Depth is set by the pipelined divider, two quotient bits per stage.
// Reset (synchronous, active low) clears all valid bits and reloads the
// register defaults; the phase input is ready once reset is released.
// ----------------------------------------------------------------------------
// adsr_envelope_shaper
// Four-segment linear envelope: phase in, level and active segment out.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_shaper (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [adsr_pkg::FRAC_BITS-1:0]      i_cfg_data,
    // phase stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [adsr_pkg::IN_W-1:0]           i_s_axis_tdata,   // phase
    // level stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic [adsr_pkg::OUT_W-1:0]               o_m_axis_tdata    // level, segment
);

    localparam int F  = adsr_pkg::FRAC_BITS;
    localparam int BW = adsr_pkg::BND_W;
    localparam int PW = adsr_pkg::PROD_W;

    // configuration registers and derived boundaries
    logic [F-1:0]  r_atk_len, r_atk_lvl, r_dec_len, r_sus_len, r_sus_lvl, r_rel_len;
    logic [BW-1:0] r_b2, r_b3, r_b4;

    // pipeline
    logic            w_adv;
    logic            r1_v;
    logic [F-1:0]    r1_phase;
    logic [F-1:0]    n2_x1, n2_y1, n2_x2, n2_y2, n2_den;
    adsr_pkg::t_side n2_side;
    logic            r2_v;
    logic [F-1:0]    r2_x1, r2_y1, r2_x2, r2_y2, r2_den;
    adsr_pkg::t_side r2_side;
    logic            r3_v;
    logic [PW-1:0]   r3_p1;
    logic [F-1:0]    r3_x2, r3_y2, r3_den;
    adsr_pkg::t_side r3_side;
    logic            r4_v;
    logic [PW-1:0]   r4_p1, r4_p2;
    logic [F-1:0]    r4_den;
    adsr_pkg::t_side r4_side;
    logic            r5_v;
    logic [PW-1:0]   r5_num;
    logic [F-1:0]    r5_den;
    adsr_pkg::t_side r5_side;
    logic            w_div_v;
    logic [F-1:0]    w_quot;
    adsr_pkg::t_side w_div_side;
    logic            r_out_v;
    logic [F-1:0]    r_out_level;
    logic [adsr_pkg::SEG_W-1:0] r_out_seg;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atk_len <= adsr_pkg::RST_ATK_LEN;
            r_atk_lvl <= adsr_pkg::RST_ATK_LVL;
            r_dec_len <= adsr_pkg::RST_DEC_LEN;
            r_sus_len <= adsr_pkg::RST_SUS_LEN;
            r_sus_lvl <= adsr_pkg::RST_SUS_LVL;
            r_rel_len <= adsr_pkg::RST_REL_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adsr_pkg::REG_ATK_LEN: r_atk_len <= i_cfg_data;
                adsr_pkg::REG_ATK_LVL: r_atk_lvl <= i_cfg_data;
                adsr_pkg::REG_DEC_LEN: r_dec_len <= i_cfg_data;
                adsr_pkg::REG_SUS_LEN: r_sus_len <= i_cfg_data;
                adsr_pkg::REG_SUS_LVL: r_sus_lvl <= i_cfg_data;
                adsr_pkg::REG_REL_LEN: r_rel_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // running boundary sums, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_b2 <= BW'(r_atk_len) + BW'(r_dec_len);
        r_b3 <= BW'(r_atk_len) + BW'(r_dec_len) + BW'(r_sus_len);
        r_b4 <= BW'(r_atk_len) + BW'(r_dec_len) + BW'(r_sus_len) + BW'(r_rel_len);
    end

    // whole pipeline moves when the output register is free
    assign w_adv           = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // stage 2: segment select and multiplier operands
    always_comb begin
        logic [BW-1:0] pe;
        pe      = BW'(r1_phase);
        n2_x1   = '0;
        n2_y1   = '0;
        n2_x2   = '0;
        n2_y2   = '0;
        n2_den  = '0;
        n2_side = '0;
        if (pe <= BW'(r_atk_len)) begin
            n2_x1        = r_atk_lvl;
            n2_y1        = r1_phase;
            n2_den       = r_atk_len;
            n2_side.seg  = adsr_pkg::SEG_ATTACK;
            n2_side.bypass = (r_atk_len == '0);
            n2_side.blev = r_atk_lvl;
        end else if (pe <= r_b2) begin
            // attack_level * (end - phase) + sustain_level * (phase - start)
            n2_x1        = r_atk_lvl;
            n2_y1        = F'(r_b2 - pe);
            n2_x2        = r_sus_lvl;
            n2_y2        = F'(pe - BW'(r_atk_len));
            n2_den       = r_dec_len;
            n2_side.seg  = adsr_pkg::SEG_DECAY;
            n2_side.bypass = (r_dec_len == '0);
            n2_side.blev = r_sus_lvl;
        end else if (pe <= r_b3) begin
            n2_side.seg  = adsr_pkg::SEG_SUSTAIN;
            n2_side.bypass = 1'b1;
            n2_side.blev = r_sus_lvl;
        end else if (pe <= r_b4) begin
            n2_x1        = r_sus_lvl;
            n2_y1        = F'(r_b4 - pe);
            n2_den       = r_rel_len;
            n2_side.seg  = adsr_pkg::SEG_RELEASE;
            n2_side.bypass = (r_rel_len == '0);
        end else begin
            n2_side.seg  = adsr_pkg::SEG_DONE;
            n2_side.bypass = 1'b1;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r1_v    <= i_s_axis_tvalid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_out_v <= w_div_v;
        end
    end

    // payload: capture, select, two products, sum, output
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_phase    <= i_s_axis_tdata[F-1:0];
            r2_x1       <= n2_x1;
            r2_y1       <= n2_y1;
            r2_x2       <= n2_x2;
            r2_y2       <= n2_y2;
            r2_den      <= n2_den;
            r2_side     <= n2_side;
            r3_p1       <= r2_x1 * r2_y1;
            r3_x2       <= r2_x2;
            r3_y2       <= r2_y2;
            r3_den      <= r2_den;
            r3_side     <= r2_side;
            r4_p1       <= r3_p1;
            r4_p2       <= r3_x2 * r3_y2;
            r4_den      <= r3_den;
            r4_side     <= r3_side;
            r5_num      <= r4_p1 + r4_p2;
            r5_den      <= r4_den;
            r5_side     <= r4_side;
            r_out_level <= w_div_side.bypass ? w_div_side.blev : w_quot;
            r_out_seg   <= w_div_side.seg;
        end
    end

    // numerator / length
    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r5_v),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (w_div_v),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = adsr_pkg::OUT_W'({r_out_seg, r_out_level});

endmodule

`default_nettype wire

FILE: design/adsr_checker.sv
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks of the envelope shaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adsr_envelope_shaper_macros.svh"

module adsr_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_s_axis_tready,
    input  wire logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    input  wire logic [adsr_pkg::OUT_W-1:0]    o_m_axis_tdata
);

    localparam int F = adsr_pkg::FRAC_BITS;
    localparam int W = adsr_pkg::SEG_W;

    // reset empties the output register
    `ADSR_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

    // a waiting result blocks new transfers on the input side
    `ADSR_ASSERT(a_stall_blocks, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready, "input ready while output stalled")

    // finished segment always reports zero level
    `ADSR_ASSERT(a_done_zero, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[F+W-1:F] == adsr_pkg::SEG_DONE) |-> (o_m_axis_tdata[F-1:0] == '0), "nonzero level after release")

    // stalled result holds
    `ADSR_ASSERT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind adsr_envelope_shaper adsr_checker u_checker (.*);

`default_nettype wire

FILE: sim/adsr_envelope_shaper_tb.sv
// ----------------------------------------------------------------------------
// adsr_envelope_shaper_tb
// Self-checking bench for the four-segment envelope shaper. A table of corner
// phases and register settings runs first, then randomized register settings
// with phases clustered around the segment boundaries. Each accepted phase is
// scored against its table entry or an in-bench envelope calculation, under
// varying source idle and sink stall rates, one long output hold-off and a drain pause per random setting.
// ----------------------------------------------------------------------------

module adsr_envelope_shaper_tb;

    localparam int FRAC_BITS       = adsr_pkg::FRAC_BITS;
    localparam int SEG_W           = adsr_pkg::SEG_W;
    localparam int CFG_IDX_W       = adsr_pkg::CFG_IDX_W;
    localparam int BND_W           = adsr_pkg::BND_W;
    localparam int IN_W            = adsr_pkg::IN_W;
    localparam int OUT_W           = adsr_pkg::OUT_W;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 8;
    localparam int RUN_LIMIT       = 200000;
    localparam int SETTLE_CYCLES   = 40;      // well past the pipeline depth
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 191;
    localparam int PHASE_MAX       = (1 << FRAC_BITS) - 1;

    // Register indexes past the end of the map; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_NONE   = '0;   // filler on phase rows

    // Idle mixes per random phase: none, source idle, sink stall, both light
    localparam int SRC_IDLE_PCT [4] = '{0, 66, 0, 10};
    localparam int SNK_STALL_PCT[4] = '{0, 0, 66, 10};

    typedef struct packed {
        logic [FRAC_BITS-1:0] level;
        logic [SEG_W-1:0]     seg;
    } t_env_point;

    typedef enum logic {ROW_PHASE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [FRAC_BITS-1:0] val;      // phase, or register data
        logic                 typed;    // expected point given in the row
        logic [FRAC_BITS-1:0] level;
        logic [SEG_W-1:0]     seg;
    } t_row;

    // Corner table: walked in order, writes wait for the pipeline to drain
    localparam int N_ROWS = 36;
    localparam t_row CORNER_ROWS [N_ROWS] = '{
        // reset settings: bounds at 8192, 16384, 49152, 65536
        '{ROW_PHASE, REG_NONE, 16'd0,     1'b1, 16'd0,     adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd8192,  1'b1, 16'd65535, adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd8193,  1'b0, '0,        '0},
        '{ROW_PHASE, REG_NONE, 16'd12288, 1'b0, '0,        '0},
        '{ROW_PHASE, REG_NONE, 16'd16384, 1'b1, 16'd32768, adsr_pkg::SEG_DECAY},
        '{ROW_PHASE, REG_NONE, 16'd16385, 1'b1, 16'd32768, adsr_pkg::SEG_SUSTAIN},
        '{ROW_PHASE, REG_NONE, 16'd49152, 1'b1, 16'd32768, adsr_pkg::SEG_SUSTAIN},
        '{ROW_PHASE, REG_NONE, 16'd49153, 1'b0, '0,        '0},
        '{ROW_PHASE, REG_NONE, 16'd65535, 1'b1, 16'd2,     adsr_pkg::SEG_RELEASE},
        // empty release: never selected, phases past sustain are finished
        '{ROW_WRITE, adsr_pkg::REG_REL_LEN, 16'd0, 1'b0, '0, '0},
        '{ROW_PHASE, REG_NONE, 16'd49153, 1'b1, 16'd0,     adsr_pkg::SEG_DONE},
        '{ROW_PHASE, REG_NONE, 16'd65535, 1'b1, 16'd0,     adsr_pkg::SEG_DONE},
        // empty attack: phase 0 gives the peak level
        '{ROW_WRITE, adsr_pkg::REG_ATK_LEN, 16'd0, 1'b0, '0, '0},
        '{ROW_PHASE, REG_NONE, 16'd0,     1'b1, 16'd65535, adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd1,     1'b0, '0,        '0},
        // empty decay: skipped straight into sustain
        '{ROW_WRITE, adsr_pkg::REG_DEC_LEN, 16'd0, 1'b0, '0, '0},
        '{ROW_PHASE, REG_NONE, 16'd1,     1'b1, 16'd32768, adsr_pkg::SEG_SUSTAIN},
        // writes past the register map must not land anywhere
        '{ROW_WRITE, REG_SPARE6, 16'hffff, 1'b0, '0, '0},
        '{ROW_WRITE, REG_SPARE7, 16'h1234, 1'b0, '0, '0},
        '{ROW_PHASE, REG_NONE, 16'd0,     1'b1, 16'd65535, adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd32768, 1'b1, 16'd32768, adsr_pkg::SEG_SUSTAIN},
        '{ROW_PHASE, REG_NONE, 16'd32769, 1'b1, 16'd0,     adsr_pkg::SEG_DONE},
        // full-scale lengths: later bounds lie beyond the phase range
        '{ROW_WRITE, adsr_pkg::REG_ATK_LEN, 16'hffff, 1'b0, '0, '0},
        '{ROW_WRITE, adsr_pkg::REG_DEC_LEN, 16'hffff, 1'b0, '0, '0},
        '{ROW_WRITE, adsr_pkg::REG_SUS_LEN, 16'hffff, 1'b0, '0, '0},
        '{ROW_WRITE, adsr_pkg::REG_SUS_LVL, 16'd0,    1'b0, '0, '0},
        '{ROW_WRITE, adsr_pkg::REG_REL_LEN, 16'hffff, 1'b0, '0, '0},
        '{ROW_PHASE, REG_NONE, 16'd65535, 1'b1, 16'd65535, adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd1,     1'b1, 16'd1,     adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd32768, 1'b1, 16'd32768, adsr_pkg::SEG_ATTACK},
        // one-step attack from zero, decay rising to full scale
        '{ROW_WRITE, adsr_pkg::REG_ATK_LEN, 16'd1,    1'b0, '0, '0},
        '{ROW_WRITE, adsr_pkg::REG_ATK_LVL, 16'd0,    1'b0, '0, '0},
        '{ROW_WRITE, adsr_pkg::REG_SUS_LVL, 16'hffff, 1'b0, '0, '0},
        '{ROW_PHASE, REG_NONE, 16'd1,     1'b1, 16'd0,     adsr_pkg::SEG_ATTACK},
        '{ROW_PHASE, REG_NONE, 16'd2,     1'b1, 16'd1,     adsr_pkg::SEG_DECAY},
        '{ROW_PHASE, REG_NONE, 16'd65535, 1'b1, 16'd65534, adsr_pkg::SEG_DECAY}
    };

    // DUT ports, all driven from time zero
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [FRAC_BITS-1:0] i_cfg_data      = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;

    // Shadow copy of the register file
    logic [FRAC_BITS-1:0] cfg_atk_len = adsr_pkg::RST_ATK_LEN;
    logic [FRAC_BITS-1:0] cfg_atk_lvl = adsr_pkg::RST_ATK_LVL;
    logic [FRAC_BITS-1:0] cfg_dec_len = adsr_pkg::RST_DEC_LEN;
    logic [FRAC_BITS-1:0] cfg_sus_len = adsr_pkg::RST_SUS_LEN;
    logic [FRAC_BITS-1:0] cfg_sus_lvl = adsr_pkg::RST_SUS_LVL;
    logic [FRAC_BITS-1:0] cfg_rel_len = adsr_pkg::RST_REL_LEN;

    t_env_point points_in_flight[$];
    t_env_point pending_point = '0;   // expectation riding with the offered phase
    t_env_point got_point;
    t_env_point want_point;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int fail_cnt      = 0;
    int n_phases_in   = 0;
    int n_results     = 0;
    int n_writes      = 0;

    adsr_envelope_shaper dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // phase
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)     // level, segment
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Envelope at a phase for the current register settings
    function automatic t_env_point envelope_at(input logic [FRAC_BITS-1:0] ph);
        logic [BND_W-1:0] b1, b2, b3, b4;
        logic [63:0]      off;
        t_env_point       pt;
        b1 = BND_W'(cfg_atk_len);
        b2 = b1 + BND_W'(cfg_dec_len);
        b3 = b2 + BND_W'(cfg_sus_len);
        b4 = b3 + BND_W'(cfg_rel_len);
        if (BND_W'(ph) <= b1) begin
            pt.seg = adsr_pkg::SEG_ATTACK;
            if (cfg_atk_len == '0)
                pt.level = cfg_atk_lvl;
            else
                pt.level = FRAC_BITS'((64'(cfg_atk_lvl) * 64'(ph)) / 64'(cfg_atk_len));
        end else if (BND_W'(ph) <= b2) begin
            pt.seg = adsr_pkg::SEG_DECAY;
            off    = 64'(ph) - 64'(b1);
            if (cfg_dec_len == '0)
                pt.level = cfg_sus_lvl;
            else
                pt.level = FRAC_BITS'((64'(cfg_atk_lvl) * (64'(cfg_dec_len) - off)
                                       + 64'(cfg_sus_lvl) * off) / 64'(cfg_dec_len));
        end else if (BND_W'(ph) <= b3) begin
            pt.seg   = adsr_pkg::SEG_SUSTAIN;
            pt.level = cfg_sus_lvl;
        end else if (BND_W'(ph) <= b4) begin
            pt.seg = adsr_pkg::SEG_RELEASE;
            off    = 64'(ph) - 64'(b3);
            if (cfg_rel_len == '0)
                pt.level = '0;
            else
                pt.level = FRAC_BITS'((64'(cfg_sus_lvl) * (64'(cfg_rel_len) - off))
                                      / 64'(cfg_rel_len));
        end else begin
            pt.seg   = adsr_pkg::SEG_DONE;
            pt.level = '0;
        end
        return pt;
    endfunction

    // Random phase, often within three steps of a segment boundary
    function automatic logic [FRAC_BITS-1:0] pick_phase();
        int bnd [4];
        int v;
        bnd[0] = int'(cfg_atk_len);
        bnd[1] = bnd[0] + int'(cfg_dec_len);
        bnd[2] = bnd[1] + int'(cfg_sus_len);
        bnd[3] = bnd[2] + int'(cfg_rel_len);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = bnd[$urandom_range(0, 3)] + int'($urandom_range(0, 6)) - 3;
            4:          v = $urandom_range(0, 1) ? 0 : PHASE_MAX;
            default:    v = int'($urandom_range(0, PHASE_MAX));
        endcase
        if (v < 0)
            v = 0;
        else if (v > PHASE_MAX)
            v = PHASE_MAX;
        return FRAC_BITS'(v);
    endfunction

    // Segment length: empty, full scale, tiny, or moderate
    function automatic logic [FRAC_BITS-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FRAC_BITS'(PHASE_MAX);
            2:       return FRAC_BITS'(1);
            3, 4, 5: return FRAC_BITS'($urandom_range(1, 64));
            default: return FRAC_BITS'($urandom_range(0, 24000));
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return FRAC_BITS'(PHASE_MAX);
            default: return FRAC_BITS'($urandom);
        endcase
    endfunction

    // One register write; the shadow copy follows the DUT
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [FRAC_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            adsr_pkg::REG_ATK_LEN: cfg_atk_len = val;
            adsr_pkg::REG_ATK_LVL: cfg_atk_lvl = val;
            adsr_pkg::REG_DEC_LEN: cfg_dec_len = val;
            adsr_pkg::REG_SUS_LEN: cfg_sus_len = val;
            adsr_pkg::REG_SUS_LVL: cfg_sus_lvl = val;
            adsr_pkg::REG_REL_LEN: cfg_rel_len = val;
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    // Offer one phase, with random idle cycles first; returns at the transfer
    task automatic offer_phase(input logic [FRAC_BITS-1:0] ph, input t_env_point want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= IN_W'($urandom);
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'(ph);
        pending_point   <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic settle_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (points_in_flight.size() != 0);
    endtask

    // Sink ready: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_req != hold_ack) begin
                hold_ack        = hold_req;
                hold_left       = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Scoreboard: queue on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                points_in_flight = {points_in_flight, pending_point};
                n_phases_in++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_point.level = o_m_axis_tdata[FRAC_BITS-1:0];
                got_point.seg   = o_m_axis_tdata[FRAC_BITS +: SEG_W];
                n_results++;
                if (points_in_flight.size() == 0) begin
                    if (fail_cnt < MAX_REPORTS)
                        $display("[%0t] unexpected result: level %0d segment %0d",
                                 $realtime, got_point.level, got_point.seg);
                    fail_cnt++;
                end else begin
                    want_point = points_in_flight.pop_front();
                    if (got_point.level !== want_point.level
                        || got_point.seg !== want_point.seg) begin
                        if (fail_cnt < MAX_REPORTS)
                            $display("[%0t] mismatch: level %0d (exp %0d), segment %0d (exp %0d)",
                                     $realtime, got_point.level, want_point.level,
                                     got_point.seg, want_point.seg);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("timeout at cycle %0d, %0d results outstanding",
                     cycle_cnt, points_in_flight.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [FRAC_BITS-1:0] ph;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner table
        for (int r = 0; r < N_ROWS; r++) begin
            if (CORNER_ROWS[r].kind == ROW_WRITE) begin
                settle_results();
                write_reg(CORNER_ROWS[r].idx, CORNER_ROWS[r].val);
            end else if (CORNER_ROWS[r].typed) begin
                offer_phase(CORNER_ROWS[r].val,
                            t_env_point'{CORNER_ROWS[r].level, CORNER_ROWS[r].seg});
            end else begin
                offer_phase(CORNER_ROWS[r].val, envelope_at(CORNER_ROWS[r].val));
            end
        end

        // random settings, one per phase, each with its own idle mix
        for (int p = 0; p < N_PHASES; p++) begin
            settle_results();
            src_idle_pct  <= SRC_IDLE_PCT[p % 4];
            snk_stall_pct <= SNK_STALL_PCT[p % 4];
            for (int r = adsr_pkg::REG_ATK_LEN; r <= adsr_pkg::REG_REL_LEN; r++)
                write_reg(CFG_IDX_W'(r),
                          (r == adsr_pkg::REG_ATK_LVL || r == adsr_pkg::REG_SUS_LVL)
                          ? pick_level() : pick_length());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7,
                          FRAC_BITS'($urandom));
            // back-pressure the whole pipeline while phases keep coming
            if (p == 0)
                hold_req <= hold_req + 1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2)
                    settle_results();
                ph = pick_phase();
                offer_phase(ph, envelope_at(ph));
            end
        end

        settle_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d phases in, %0d results scored, %0d register writes, %0d errors.",
                 n_phases_in, n_results, n_writes, fail_cnt);
        $display("Corners of every segment, empty and full-scale lengths, unmapped writes,");
        $display("idle/stall mixes, a %0d-cycle output hold-off and a drain pause.",
                 HOLD_CYCLES);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
